>>> hdl/chf_pkg.sv
// Shared types and constants of the Cholesky factorizer.
`timescale 1ns / 1ps
package chf_pkg;
   localparam int MAX_SIZE_DEFAULT = 32;
   localparam logic [5:0] SIZE_RESET = 6'd32;
   localparam logic [63:0] SQRT_CAP = (64'd1 << 46) - 64'd1;
   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic start;
      logic is_sqrt;
   } arith_req_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DOT  = 5'b00010,
      ST_CALC = 5'b00100,
      ST_WAIT = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;
endpackage

>>> hdl/chf_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module chf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 528
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end
endmodule

>>> hdl/chf_arith.sv
// Iterative square root and fixed-point divider.
`timescale 1ns / 1ps
module chf_arith (
   input  logic                 clock,
   input  logic                 reset,
   input  chf_pkg::arith_req_type req,
   input  logic signed [63:0]   r_value,
   input  logic signed [31:0]   divisor,
   output logic                 done,
   output logic [31:0]          result
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        sqrt_ff, sqrt_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [34:0] rem_ff, rem_in;
   logic [63:0] x_ff, x_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] res_ff, res_in;
   logic [31:0] dv_ff, dv_in;

   logic [63:0] mag, ur;
   logic [34:0] rn, trial;

   always_comb begin
      mag = r_value[63] ? (64'd0 - r_value) : r_value;
      ur = (r_value > $signed(chf_pkg::SQRT_CAP)) ? chf_pkg::SQRT_CAP : r_value;
      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      x_in = x_ff;
      q_in = q_ff;
      res_in = res_ff;
      dv_in = dv_ff;
      rn = '0;
      trial = '0;
      if (req.start) begin
         sqrt_in = req.is_sqrt;
         neg_in = r_value[63];
         q_in = '0;
         dv_in = divisor;
         if (req.is_sqrt) begin
            busy_in = 1'b1;
            rem_in = '0;
            x_in = {2'b00, ur[45:0], 16'b0};
            cnt_in = 5'd31;
         end else if (divisor <= 0) begin
            done_in = 1'b1;
            res_in = (r_value > 0) ? chf_pkg::SAT_POS :
                     (r_value < 0) ? chf_pkg::SAT_NEG : 32'd0;
         end else if (mag >= ({32'd0, divisor} << 15)) begin
            done_in = 1'b1;
            res_in = r_value[63] ? chf_pkg::SAT_NEG : chf_pkg::SAT_POS;
         end else begin
            busy_in = 1'b1;
            rem_in = {4'b0, mag[45:15]};
            x_in = {mag[14:0], 16'b0, 33'b0};
            cnt_in = 5'd30;
         end
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            rn = {rem_ff[32:0], x_ff[63:62]};
            trial = {1'b0, q_ff, 2'b01};
            x_in = {x_ff[61:0], 2'b00};
            if (rn >= trial) begin
               rem_in = rn - trial;
               q_in = {q_ff[30:0], 1'b1};
            end else begin
               rem_in = rn;
               q_in = {q_ff[30:0], 1'b0};
            end
         end else begin
            rn = {rem_ff[33:0], x_ff[63]};
            trial = {3'b0, dv_ff};
            x_in = {x_ff[62:0], 1'b0};
            if (rn >= trial) begin
               rem_in = rn - trial;
               q_in = {q_ff[30:0], 1'b1};
            end else begin
               rem_in = rn;
               q_in = {q_ff[30:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in = (!sqrt_ff && neg_ff) ? (32'd0 - q_in) : q_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sqrt_ff <= sqrt_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      x_ff <= x_in;
      q_ff <= q_in;
      res_ff <= res_in;
      dv_ff <= dv_in;
   end

   assign done = done_ff;
   assign result = res_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.start) else $error("start while busy");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !busy_in) |=> done_ff) else $error("busy ended without done");
endmodule

>>> hdl/cholesky_factorizer.sv
// Top level of the streaming Cholesky factorizer.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/stall    | req_a_value
//  rsp     | out | rsp_valid/stall    | rsp_l_value, row/col index, not_positive, last
//  csr     | in  | csr_valid/ready    | csr_matrix_size
//
// Element (i, j): a dot product over the factor RAM, a launch, then the square root or the
// divider (a saturating divide skips the iterations and a non-positive pivot skips the
// unit), and loading of the output register; the block then returns to idle to accept.
// Reset is synchronous; the RAM holds no reset state.
// A result waits in its output register while rsp_stall is high and the next item is
// taken meanwhile; req_stall is also high while csr_valid is high.
`timescale 1ns / 1ps
module cholesky_factorizer #(
   parameter int MAX_SIZE = chf_pkg::MAX_SIZE_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_a_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_l_value,
   output logic [4:0]         rsp_row_index,
   output logic [4:0]         rsp_col_index,
   output logic               rsp_not_positive,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [5:0]         csr_matrix_size
);
   localparam int DEPTH = MAX_SIZE * (MAX_SIZE + 1) / 2;
   localparam int AW = $clog2(DEPTH);
   localparam int IW = $clog2(MAX_SIZE);
   localparam int NW = $clog2(MAX_SIZE + 1);

   chf_pkg::state_type state_ff, state_in;
   logic [5:0]    size_ff, size_in;
   logic [IW-1:0] row_ff, row_in, col_ff, col_in;
   logic [AW-1:0] bi_ff, bi_in, bj_ff, bj_in;
   logic [IW-1:0] ci_ff, ci_in, cj_ff, cj_in;
   logic [AW-1:0] cbi_ff, cbi_in, cbj_ff, cbj_in;
   logic          pivot_ff, pivot_in;
   logic signed [31:0] a_ff, a_in;
   logic [IW:0]   k_ff, k_in;
   logic          v1_ff, v2_ff, d1_ff;
   logic signed [63:0] prod_ff, prod_in, sum_ff, sum_in;
   logic signed [31:0] dv_ff, dv_in;
   logic [31:0]   l_ff, l_in;
   logic          rv_ff, rv_in;
   logic [31:0]   ol_ff, ol_in;
   logic [IW-1:0] oi_ff, oi_in, oj_ff, oj_in;
   logic          op_ff, op_in, olast_ff, olast_in;

   logic [NW-1:0] n;
   logic          accept, issue_dot, issue_diag, wr_en, done;
   logic [AW-1:0] ra_addr, rb_addr;
   logic [31:0]   ra_data, rb_data, arith_res;
   logic signed [63:0] r_val;
   chf_pkg::arith_req_type areq;

   always_comb begin
      if (size_ff == 6'd0) begin
         n = NW'(1);
      end else if (32'(size_ff) > 32'(MAX_SIZE)) begin
         n = NW'(MAX_SIZE);
      end else begin
         n = NW'(size_ff);
      end
   end

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != chf_pkg::ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == chf_pkg::ST_IDLE);
   assign issue_dot = (state_ff == chf_pkg::ST_DOT) && (k_ff < {1'b0, cj_ff});
   assign issue_diag = (state_ff == chf_pkg::ST_DOT) && (k_ff == {1'b0, cj_ff});
   assign ra_addr = cbi_ff + AW'(k_ff);
   assign rb_addr = cbj_ff + AW'(k_ff);
   assign r_val = 64'(a_ff) - sum_ff;

   always_comb begin
      state_in = state_ff;
      size_in = size_ff;
      row_in = row_ff;
      col_in = col_ff;
      bi_in = bi_ff;
      bj_in = bj_ff;
      ci_in = ci_ff;
      cj_in = cj_ff;
      cbi_in = cbi_ff;
      cbj_in = cbj_ff;
      pivot_in = pivot_ff;
      a_in = a_ff;
      k_in = k_ff;
      prod_in = prod_ff;
      sum_in = sum_ff;
      dv_in = dv_ff;
      l_in = l_ff;
      rv_in = rv_ff && rsp_stall;
      ol_in = ol_ff;
      oi_in = oi_ff;
      oj_in = oj_ff;
      op_in = op_ff;
      olast_in = olast_ff;
      wr_en = 1'b0;
      areq = '0;
      if (v1_ff) begin
         prod_in = $signed(ra_data) * $signed(rb_data);
      end
      if (v2_ff) begin
         sum_in = sum_ff + (prod_ff >>> 16);
      end
      if (d1_ff) begin
         dv_in = rb_data;
      end
      case (state_ff)
         chf_pkg::ST_IDLE: begin
            if (csr_valid) begin
               size_in = csr_matrix_size;
               row_in = '0;
               col_in = '0;
               bi_in = '0;
               bj_in = '0;
               pivot_in = 1'b0;
            end else if (accept) begin
               a_in = req_a_value;
               k_in = '0;
               sum_in = '0;
               ci_in = row_ff;
               cj_in = col_ff;
               cbi_in = bi_ff;
               cbj_in = bj_ff;
               if ({1'b0, row_ff} >= (IW + 1)'(n)) begin
                  ci_in = '0;
                  cj_in = '0;
                  cbi_in = '0;
                  cbj_in = '0;
               end else if (col_ff > row_ff) begin
                  cj_in = '0;
                  cbj_in = '0;
               end
               if (ci_in == '0 && cj_in == '0) begin
                  pivot_in = 1'b0;
               end
               state_in = chf_pkg::ST_DOT;
            end
         end
         chf_pkg::ST_DOT: begin
            if (k_ff <= {1'b0, cj_ff}) begin
               k_in = k_ff + 1'b1;
            end else if (!v1_ff && !v2_ff && !d1_ff) begin
               state_in = chf_pkg::ST_CALC;
            end
         end
         chf_pkg::ST_CALC: begin
            if (ci_ff == cj_ff && r_val <= 0) begin
               l_in = '0;
               pivot_in = 1'b1;
               state_in = chf_pkg::ST_OUT;
            end else begin
               areq.start = 1'b1;
               areq.is_sqrt = (ci_ff == cj_ff);
               state_in = chf_pkg::ST_WAIT;
            end
         end
         chf_pkg::ST_WAIT: begin
            if (done) begin
               l_in = arith_res;
               state_in = chf_pkg::ST_OUT;
            end
         end
         chf_pkg::ST_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               wr_en = 1'b1;
               rv_in = 1'b1;
               ol_in = l_ff;
               oi_in = ci_ff;
               oj_in = cj_ff;
               op_in = pivot_ff;
               olast_in = ((IW + 1)'(ci_ff) == (IW + 1)'(n) - 1'b1) &&
                          ((IW + 1)'(cj_ff) == (IW + 1)'(n) - 1'b1);
               if (cj_ff < ci_ff) begin
                  col_in = cj_ff + 1'b1;
                  bj_in = cbj_ff + AW'(cj_ff) + 1'b1;
                  row_in = ci_ff;
                  bi_in = cbi_ff;
               end else begin
                  col_in = '0;
                  bj_in = '0;
                  if ((IW + 1)'(ci_ff) + 1'b1 >= (IW + 1)'(n)) begin
                     row_in = '0;
                     bi_in = '0;
                  end else begin
                     row_in = ci_ff + 1'b1;
                     bi_in = cbi_ff + AW'(ci_ff) + 1'b1;
                  end
               end
               state_in = chf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = chf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chf_pkg::ST_IDLE;
         size_ff <= chf_pkg::SIZE_RESET;
         row_ff <= '0;
         col_ff <= '0;
         bi_ff <= '0;
         bj_ff <= '0;
         pivot_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         d1_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff <= size_in;
         row_ff <= row_in;
         col_ff <= col_in;
         bi_ff <= bi_in;
         bj_ff <= bj_in;
         pivot_ff <= pivot_in;
         v1_ff <= issue_dot;
         v2_ff <= v1_ff;
         d1_ff <= issue_diag;
         rv_ff <= rv_in;
      end
      ci_ff <= ci_in;
      cj_ff <= cj_in;
      cbi_ff <= cbi_in;
      cbj_ff <= cbj_in;
      a_ff <= a_in;
      k_ff <= k_in;
      prod_ff <= prod_in;
      sum_ff <= sum_in;
      dv_ff <= dv_in;
      l_ff <= l_in;
      ol_ff <= ol_in;
      oi_ff <= oi_in;
      oj_ff <= oj_in;
      op_ff <= op_in;
      olast_ff <= olast_in;
   end

   chf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (cbi_ff + AW'(cj_ff)),
      .wr_data   (l_ff),
      .rd_a_addr (ra_addr),
      .rd_a_data (ra_data),
      .rd_b_addr (rb_addr),
      .rd_b_data (rb_data)
   );

   chf_arith u_arith (
      .clock   (clock),
      .reset   (reset),
      .req     (areq),
      .r_value (r_val),
      .divisor (dv_ff),
      .done    (done),
      .result  (arith_res)
   );

   assign rsp_valid = rv_ff;
   assign rsp_l_value = ol_ff;
   assign rsp_row_index = 5'(oi_ff);
   assign rsp_col_index = 5'(oj_ff);
   assign rsp_not_positive = op_ff;
   assign rsp_last = olast_ff;

   a_accept_dot: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_valid) |=> state_ff == chf_pkg::ST_DOT) else $error("accept lost");
   a_mac_chain: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff)) else $error("product without read");
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      done |-> state_ff == chf_pkg::ST_WAIT) else $error("stray arith done");
   a_write_out: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid) else $error("write without result");
endmodule
